// ----- hw/rtl/dqd_pkg.sv -----
// dqd_pkg: shared types, constants and the direction table of the
// dual quadrature decoder with speed measurement.
// No dependencies; used by dqd_scaler and the top level.
package dqd_pkg;

    // default build parameters
    localparam int COUNTS_PER_REV = 4000;
    localparam int AXES           = 2;

    // state storage always has room for two axes
    localparam int MAX_AXES = 2;

    // scale factors: tenths of a degree per revolution, rpm = 60 * 100
    localparam int ANGLE_FACTOR = 3600;
    localparam int RPM_FACTOR   = 6000;

    // pipeline depth: one input stage in the top level plus the scaler stages
    localparam int SCL_STAGES  = 7;
    localparam int PIPE_STAGES = SCL_STAGES + 1;

    // event kind carried in tuser
    typedef enum logic [1:0] {
        MODE_EDGE  = 2'd0,
        MODE_INDEX = 2'd1,
        MODE_SPEED = 2'd2,
        MODE_IDLE  = 2'd3
    } t_mode;

    // x4 direction table, index = {previous BA, current BA}
    localparam logic signed [1:0] DIR_TABLE [16] = '{
         2'sd0,  2'sd1, -2'sd1,  2'sd0,
        -2'sd1,  2'sd0,  2'sd0,  2'sd1,
         2'sd1,  2'sd0,  2'sd0, -2'sd1,
         2'sd0, -2'sd1,  2'sd1,  2'sd0
    };

    // count increment for a state transition, sign-extended to 32 bits
    function automatic logic [31:0] dir_step(input logic [1:0] prev_ab,
                                             input logic [1:0] cur_ab);
        logic signed [1:0] d;
        d = DIR_TABLE[{prev_ab, cur_ab}];
        return {{30{d[1]}}, d};
    endfunction

endpackage

// ----- hw/rtl/dqd_scaler.sv -----
// dqd_scaler: pipelined signed scaling q = trunc(v * FACTOR / CPR), low 32 bits.
// Seven stages, each advanced by its own enable from the top level.
// Depends on dqd_pkg for the stage count.
module dqd_scaler #(
    parameter int CPR    = dqd_pkg::COUNTS_PER_REV,
    parameter int FACTOR = dqd_pkg::ANGLE_FACTOR
) (
    input  logic                            i_clk,
    input  logic [dqd_pkg::SCL_STAGES-1:0]  i_en,
    input  logic [31:0]                     i_value,
    output logic [31:0]                     o_result
);

    // |v| = mh * 2^16 + ml, FACTOR * 2^16 = A * CPR + B
    localparam int A_CONST  = (FACTOR * 65536) / CPR;
    localparam int B_CONST  = (FACTOR * 65536) % CPR;
    // reciprocal: R0 = floor(2^S / CPR), S = 31 + floor(log2 CPR)
    localparam int S_SHIFT  = 31 + $clog2(CPR + 1) - 1;
    localparam longint unsigned R0_WIDE = (64'd1 << S_SHIFT) / CPR;
    localparam logic [31:0] R0      = R0_WIDE[31:0];
    localparam logic [31:0] A_VAL   = 32'(A_CONST);
    localparam logic [15:0] B_VAL   = 16'(B_CONST);
    localparam logic [15:0] F_VAL   = 16'(FACTOR);
    // the remainder estimate stays below three times CPR
    localparam int RW = $clog2(3 * CPR) + 1;
    localparam logic [RW-1:0] CPR_RW = RW'(CPR);

    // stage 1
    logic [31:0]   r_mag;
    logic          r_s1;
    // stage 2
    logic [31:0]   r_ph2;
    logic [31:0]   r_pb;
    logic [31:0]   r_pf;
    logic          r_s2;
    // stage 3
    logic [31:0]   r_x3;
    logic [31:0]   r_ph3;
    logic          r_s3;
    // stage 4
    logic [63:0]   r_prod;
    logic [RW-1:0] r_xl4;
    logic [31:0]   r_ph4;
    logic          r_s4;
    // stage 5
    logic [31:0]   r_qe;
    logic [RW-1:0] r_qc;
    logic [RW-1:0] r_xl5;
    logic [31:0]   r_ph5;
    logic          r_s5;
    // stage 6
    logic [31:0]   r_t;
    logic [1:0]    r_corr;
    logic          r_s6;
    // stage 7
    logic [31:0]   r_res;

    logic [31:0]   n_qe;
    logic [RW-1:0] n_rem;
    logic [RW-1:0] n_rem1;
    logic          n_c1;
    logic          n_c2;
    logic [31:0]   n_add;

    // quotient estimate and remainder correction
    always_comb begin
        n_qe   = 32'(r_prod >> S_SHIFT);
        n_rem  = r_xl5 - r_qc;
        n_c1   = (n_rem >= CPR_RW);
        n_rem1 = n_c1 ? (n_rem - CPR_RW) : n_rem;
        n_c2   = (n_rem1 >= CPR_RW);
        // -(t + c) = ~t + 1 - c
        n_add  = r_s6 ? (32'd1 - {30'b0, r_corr}) : {30'b0, r_corr};
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_s1  <= i_value[31];
            r_mag <= i_value[31] ? (32'd0 - i_value) : i_value;
        end
        if (i_en[1]) begin
            r_s2  <= r_s1;
            r_ph2 <= 32'(r_mag[31:16] * A_VAL);
            r_pb  <= 32'(r_mag[31:16]) * 32'(B_VAL);
            r_pf  <= 32'(r_mag[15:0]) * 32'(F_VAL);
        end
        if (i_en[2]) begin
            r_s3  <= r_s2;
            r_ph3 <= r_ph2;
            r_x3  <= r_pb + r_pf;
        end
        if (i_en[3]) begin
            r_s4   <= r_s3;
            r_ph4  <= r_ph3;
            r_xl4  <= r_x3[RW-1:0];
            r_prod <= 64'(r_x3) * 64'(R0);
        end
        if (i_en[4]) begin
            r_s5  <= r_s4;
            r_ph5 <= r_ph4;
            r_xl5 <= r_xl4;
            r_qe  <= n_qe;
            r_qc  <= n_qe[RW-1:0] * CPR_RW;
        end
        if (i_en[5]) begin
            r_s6   <= r_s5;
            r_t    <= r_ph5 + r_qe;
            r_corr <= {1'b0, n_c1} + {1'b0, n_c2};
        end
        if (i_en[6]) begin
            r_res <= (r_t ^ {32{r_s6}}) + n_add;
        end
    end

    assign o_result = r_res;

endmodule

// ----- hw/rtl/dual_quadrature_decoder_speed_unit.sv -----
// Two-axis x4 quadrature decoder with index clear and periodic speed latch.
// Throughput: one event per cycle; each stage stalls only when full and blocked.
// Reset (synchronous, active low): counts, AB history, index flags, speed
// samples and all stage valid bits cleared; no clearing pass.
// Depends on dqd_pkg and dqd_scaler.
module dual_quadrature_decoder_speed_unit #(
    parameter int COUNTS_PER_REV = dqd_pkg::COUNTS_PER_REV,
    parameter int AXES           = dqd_pkg::AXES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // input event stream
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    input  logic [7:0]    i_s_axis_tdata,   // [0] axis, [1] a_level, [2] b_level
    input  logic [1:0]    i_s_axis_tuser,   // [1:0] mode
    // result stream
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    output logic [103:0]  o_m_axis_tdata    // [31:0] position_count,
                                            // [63:32] angle_tenths,
                                            // [95:64] speed_rpm, [96] index_seen
);

    localparam int NST = dqd_pkg::PIPE_STAGES;

    // decoder state
    logic [31:0] r_count  [dqd_pkg::MAX_AXES];
    logic [1:0]  r_prev   [dqd_pkg::MAX_AXES];
    logic        r_zero   [dqd_pkg::MAX_AXES];
    logic [31:0] r_sample [dqd_pkg::MAX_AXES];
    logic [31:0] r_delta  [dqd_pkg::MAX_AXES];
    logic [31:0] n_count  [dqd_pkg::MAX_AXES];
    logic [1:0]  n_prev   [dqd_pkg::MAX_AXES];
    logic        n_zero   [dqd_pkg::MAX_AXES];
    logic [31:0] n_sample [dqd_pkg::MAX_AXES];
    logic [31:0] n_delta  [dqd_pkg::MAX_AXES];

    // pipeline control and side data
    logic [NST-1:0] r_valid;
    logic [NST-1:0] w_en;
    logic [31:0]    r_cnt_pipe  [NST];
    logic           r_flag_pipe [NST];
    logic [31:0]    r_dlt0;

    logic              w_accept;
    dqd_pkg::t_mode    w_mode;
    logic              w_axis;
    logic [1:0]        w_ab;
    logic              w_axis_ok;
    logic [31:0]       n_rep_count;
    logic [31:0]       n_rep_delta;
    logic              n_rep_flag;
    logic [31:0]       w_angle;
    logic [31:0]       w_rpm;

    assign w_mode    = dqd_pkg::t_mode'(i_s_axis_tuser);
    assign w_axis    = i_s_axis_tdata[0];
    assign w_ab      = {i_s_axis_tdata[2], i_s_axis_tdata[1]};
    assign w_axis_ok = (int'(w_axis) < AXES);

    // stage advance: a stage loads when empty or when it moves on
    always_comb begin
        w_en[NST-1] = !r_valid[NST-1] || i_m_axis_tready;
        for (int k = NST - 2; k >= 0; k--) begin
            w_en[k] = !r_valid[k] || w_en[k+1];
        end
    end

    assign o_s_axis_tready = w_en[0];
    assign w_accept        = i_s_axis_tvalid && w_en[0];

    // event decode and next state
    always_comb begin
        n_count  = r_count;
        n_prev   = r_prev;
        n_zero   = r_zero;
        n_sample = r_sample;
        n_delta  = r_delta;
        unique case (w_mode)
            dqd_pkg::MODE_EDGE: begin
                if (w_axis_ok) begin
                    n_count[w_axis] = r_count[w_axis]
                                    + dqd_pkg::dir_step(r_prev[w_axis], w_ab);
                    n_prev[w_axis]  = w_ab;
                end
            end
            dqd_pkg::MODE_INDEX: begin
                if (w_axis_ok) begin
                    n_count[w_axis] = 32'd0;
                    n_zero[w_axis]  = 1'b1;
                end
            end
            dqd_pkg::MODE_SPEED: begin
                for (int i = 0; i < dqd_pkg::MAX_AXES; i++) begin
                    if (i < AXES) begin
                        n_delta[i]  = r_count[i] - r_sample[i];
                        n_sample[i] = r_count[i];
                    end
                end
            end
            dqd_pkg::MODE_IDLE: begin
            end
        endcase
        // report the addressed axis, all zero for an axis that is not built
        n_rep_count = w_axis_ok ? n_count[w_axis] : 32'd0;
        n_rep_delta = w_axis_ok ? n_delta[w_axis] : 32'd0;
        n_rep_flag  = w_axis_ok ? n_zero[w_axis]  : 1'b0;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            for (int i = 0; i < dqd_pkg::MAX_AXES; i++) begin
                r_count[i]  <= 32'd0;
                r_prev[i]   <= 2'd0;
                r_zero[i]   <= 1'b0;
                r_sample[i] <= 32'd0;
                r_delta[i]  <= 32'd0;
            end
        end else begin
            if (w_en[0]) begin
                r_valid[0] <= w_accept;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_en[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
            if (w_accept) begin
                r_count  <= n_count;
                r_prev   <= n_prev;
                r_zero   <= n_zero;
                r_sample <= n_sample;
                r_delta  <= n_delta;
            end
        end
    end

    // side data travelling alongside the scalers
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_cnt_pipe[0]  <= n_rep_count;
            r_flag_pipe[0] <= n_rep_flag;
            r_dlt0         <= n_rep_delta;
        end
        for (int k = 1; k < NST; k++) begin
            if (w_en[k]) begin
                r_cnt_pipe[k]  <= r_cnt_pipe[k-1];
                r_flag_pipe[k] <= r_flag_pipe[k-1];
            end
        end
    end

    // angle in tenths of a degree
    dqd_scaler #(
        .CPR    (COUNTS_PER_REV),
        .FACTOR (dqd_pkg::ANGLE_FACTOR)
    ) u_angle (
        .i_clk    (i_clk),
        .i_en     (w_en[NST-1:1]),
        .i_value  (r_cnt_pipe[0]),
        .o_result (w_angle)
    );

    // speed in rpm from the latched count difference
    dqd_scaler #(
        .CPR    (COUNTS_PER_REV),
        .FACTOR (dqd_pkg::RPM_FACTOR)
    ) u_rpm (
        .i_clk    (i_clk),
        .i_en     (w_en[NST-1:1]),
        .i_value  (r_dlt0),
        .o_result (w_rpm)
    );

    // result stream
    assign o_m_axis_tvalid = r_valid[NST-1];
    assign o_m_axis_tdata  = {7'b0, r_flag_pipe[NST-1], w_rpm, w_angle, r_cnt_pipe[NST-1]};

    // a stage that has room never holds back the input
    a_ready_when_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(&r_valid) |-> o_s_axis_tready)
        else $error("input stalled while the pipeline has room");

    // an index pulse clears the axis count and sets its flag
    a_index_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_mode == dqd_pkg::MODE_INDEX && w_axis_ok)
        |=> (r_count[$past(w_axis)] == 32'd0 && r_zero[$past(w_axis)]))
        else $error("index pulse did not clear the count");

    // an edge moves the count by at most one step
    a_edge_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_mode == dqd_pkg::MODE_EDGE && w_axis_ok)
        |=> ((r_count[$past(w_axis)] - $past(r_count[w_axis])) == 32'd0 ||
             (r_count[$past(w_axis)] - $past(r_count[w_axis])) == 32'd1 ||
             (r_count[$past(w_axis)] - $past(r_count[w_axis])) == 32'hFFFF_FFFF))
        else $error("edge changed the count by more than one");

    // the index flag of axis 0 never falls outside reset
    a_flag_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_zero[0] |=> r_zero[0])
        else $error("index flag cleared without reset");

endmodule

// ----- bench/dual_quadrature_decoder_speed_unit_test.sv -----
// Self-checking bench for the two-axis quadrature decoder with speed latch.
// Needs dqd_pkg and dual_quadrature_decoder_speed_unit. It drives edge, index and speed events
// and checks every result against a cycle-free decoder model held in this file.
module dual_quadrature_decoder_speed_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;

    // one input event, as queued for the driver
    typedef struct packed {
        dqd_pkg::t_mode mode;
        logic           axis;
        logic           a_level;
        logic           b_level;
    } t_quad_event;

    // one result, as the decoder should report it
    typedef struct packed {
        logic signed [31:0] position_count;
        logic signed [31:0] angle_tenths;
        logic signed [31:0] speed_rpm;
        logic               index_seen;
    } t_axis_report;

    logic         clk;
    logic         rst_n     = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic [7:0]   s_tdata   = '0;
    logic [1:0]   s_tuser   = dqd_pkg::MODE_EDGE;
    logic         m_tready  = 1'b0;
    logic         s_tready;
    logic         m_tvalid;
    logic [103:0] m_tdata;

    t_quad_event  pending_events[$];
    t_axis_report expected_reports[$];
    t_quad_event  offered_event;

    // decoder model state
    logic signed [31:0] axis_pos[2];
    logic [1:0]         last_ab[2];
    logic               index_flag[2];
    logic signed [31:0] sampled_pos[2];
    logic signed [31:0] axis_rpm[2];

    // generator view of each axis, kept in queue order
    logic [1:0] gen_ab[2];
    logic       heading[2];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    logic hold_req     = 1'b0;
    logic hold_done    = 1'b0;
    int hold_left      = 0;
    int errors         = 0;
    int cycle_count    = 0;

    dual_quadrature_decoder_speed_unit dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),     // [0] axis, [1] a_level, [2] b_level
        .i_s_axis_tuser  (s_tuser),     // [1:0] mode
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)      // [31:0] position, [63:32] angle,
                                        // [95:64] rpm, [96] index_seen
    );

    // gray-code neighbour of an AB state, forward being the counting-up direction
    function automatic logic [1:0] next_ab(input logic [1:0] ab, input logic fwd);
        case (ab)
            2'b00: next_ab = fwd ? 2'b01 : 2'b10;
            2'b01: next_ab = fwd ? 2'b11 : 2'b00;
            2'b11: next_ab = fwd ? 2'b10 : 2'b01;
            default: next_ab = fwd ? 2'b00 : 2'b11;
        endcase
    endfunction

    // apply one event to the model state and return the report for its axis
    function automatic t_axis_report decode_event(input t_quad_event ev);
        logic [1:0]         cur;
        logic signed [31:0] delta;
        t_axis_report       rep;
        cur = {ev.b_level, ev.a_level};
        case (ev.mode)
            dqd_pkg::MODE_EDGE: begin
                if (cur == next_ab(last_ab[ev.axis], 1'b1))
                    axis_pos[ev.axis] = axis_pos[ev.axis] + 32'sd1;
                else if (cur == next_ab(last_ab[ev.axis], 1'b0))
                    axis_pos[ev.axis] = axis_pos[ev.axis] - 32'sd1;
                last_ab[ev.axis] = cur;
            end
            dqd_pkg::MODE_INDEX: begin
                axis_pos[ev.axis]   = '0;
                index_flag[ev.axis] = 1'b1;
            end
            dqd_pkg::MODE_SPEED: begin
                for (int i = 0; i < 2; i++) begin
                    delta          = axis_pos[i] - sampled_pos[i];
                    sampled_pos[i] = axis_pos[i];
                    axis_rpm[i]    = 32'(longint'(delta) * dqd_pkg::RPM_FACTOR
                                         / dqd_pkg::COUNTS_PER_REV);
                end
            end
            default: ;
        endcase
        rep.position_count = axis_pos[ev.axis];
        rep.angle_tenths   = 32'(longint'(axis_pos[ev.axis]) * dqd_pkg::ANGLE_FACTOR
                                 / dqd_pkg::COUNTS_PER_REV);
        rep.speed_rpm      = axis_rpm[ev.axis];
        rep.index_seen     = index_flag[ev.axis];
        return rep;
    endfunction

    task automatic queue_event(input dqd_pkg::t_mode mode, input logic axis, input logic a,
                               input logic b);
        t_quad_event ev;
        ev.mode    = mode;
        ev.axis    = axis;
        ev.a_level = a;
        ev.b_level = b;
        pending_events.push_back(ev);
        if (mode == dqd_pkg::MODE_EDGE)
            gen_ab[axis] = {b, a};
    endtask

    // one legal quadrature step on an axis
    task automatic step_axis(input logic axis, input logic fwd);
        logic [1:0] ab;
        ab = next_ab(gen_ab[axis], fwd);
        queue_event(dqd_pkg::MODE_EDGE, axis, ab[0], ab[1]);
    endtask

    // mostly clean motion with drifting direction, plus stutter, glitches and other events
    task automatic queue_random(input int n);
        int   r;
        logic ax;
        logic ra;
        logic rb;
        for (int k = 0; k < n; k++) begin
            r  = $urandom_range(0, 99);
            ax = 1'($urandom_range(0, 1));
            ra = 1'($urandom_range(0, 1));
            rb = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 99) < 4)
                heading[ax] = !heading[ax];
            if (r < 68)
                step_axis(ax, heading[ax]);
            else if (r < 75)
                queue_event(dqd_pkg::MODE_EDGE, ax, gen_ab[ax][0], gen_ab[ax][1]);
            else if (r < 81)
                queue_event(dqd_pkg::MODE_EDGE, ax, ra, rb);
            else if (r < 85)
                queue_event(dqd_pkg::MODE_INDEX, ax, ra, rb);
            else if (r < 96)
                queue_event(dqd_pkg::MODE_SPEED, ax, ra, rb);
            else
                queue_event(dqd_pkg::MODE_IDLE, ax, ra, rb);
        end
    endtask

    task automatic wait_drained();
        while (pending_events.size() != 0 || s_tvalid || expected_reports.size() != 0)
            @(negedge clk);
    endtask

    // clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // model reset
    initial begin
        for (int i = 0; i < 2; i++) begin
            axis_pos[i]    = '0;
            last_ab[i]     = '0;
            index_flag[i]  = 1'b0;
            sampled_pos[i] = '0;
            axis_rpm[i]    = '0;
            gen_ab[i]      = '0;
            heading[i]     = 1'b1;
        end
    end

    // driver: predicts each accepted transaction and offers the next one
    always @(posedge clk) begin : drive
        t_quad_event ev;
        if (rst_n) begin
            if (s_tvalid && s_tready)
                expected_reports.push_back(decode_event(offered_event));
            if (!s_tvalid || s_tready) begin
                if (pending_events.size() != 0 &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                    ev = pending_events.pop_front();
                    offered_event <= ev;
                    s_tvalid      <= 1'b1;
                    s_tdata       <= {5'b0, ev.b_level, ev.a_level, ev.axis};
                    s_tuser       <= ev.mode;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, started once on request
    always @(posedge clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // monitor: receiver back-pressure and result checking
    always @(posedge clk) begin : check
        t_axis_report want;
        m_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
        if (rst_n && m_tvalid && m_tready) begin
            if (expected_reports.size() == 0) begin
                $error("result transaction with no event pending: %h", m_tdata);
                errors++;
            end else begin
                want = expected_reports.pop_front();
                if ($signed(m_tdata[31:0]) !== want.position_count) begin
                    $error("position_count: expected %0d, got %0d",
                           want.position_count, $signed(m_tdata[31:0]));
                    errors++;
                end
                if ($signed(m_tdata[63:32]) !== want.angle_tenths) begin
                    $error("angle_tenths: expected %0d, got %0d",
                           want.angle_tenths, $signed(m_tdata[63:32]));
                    errors++;
                end
                if ($signed(m_tdata[95:64]) !== want.speed_rpm) begin
                    $error("speed_rpm: expected %0d, got %0d",
                           want.speed_rpm, $signed(m_tdata[95:64]));
                    errors++;
                end
                if (m_tdata[96] !== want.index_seen) begin
                    $error("index_seen: expected %0d, got %0d", want.index_seen, m_tdata[96]);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // stimulus sequence
    initial begin : stimulus
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // speed tick and unused mode straight out of reset
        queue_event(dqd_pkg::MODE_SPEED, 1'b0, 1'b0, 1'b0);
        queue_event(dqd_pkg::MODE_IDLE, 1'b1, 1'b1, 1'b1);
        // a full forward cycle on axis 0, then no change and an illegal double step
        repeat (4) step_axis(1'b0, 1'b1);
        queue_event(dqd_pkg::MODE_EDGE, 1'b0, 1'b0, 1'b0);
        queue_event(dqd_pkg::MODE_EDGE, 1'b0, 1'b1, 1'b1);
        // axis 1 runs backwards into negative counts
        repeat (5) step_axis(1'b1, 1'b0);
        // negative speed truncates toward zero
        queue_event(dqd_pkg::MODE_SPEED, 1'b1, 1'b1, 1'b0);
        queue_event(dqd_pkg::MODE_SPEED, 1'b0, 1'b0, 1'b1);
        // index clears the count and sets the flag, levels ignored
        queue_event(dqd_pkg::MODE_INDEX, 1'b0, 1'b1, 1'b1);
        step_axis(1'b0, 1'b1);
        queue_event(dqd_pkg::MODE_INDEX, 1'b1, 1'b0, 1'b1);
        queue_event(dqd_pkg::MODE_SPEED, 1'b1, 1'b1, 1'b1);
        queue_event(dqd_pkg::MODE_IDLE, 1'b0, 1'b0, 1'b0);
        step_axis(1'b1, 1'b1);
        step_axis(1'b1, 1'b1);
        queue_event(dqd_pkg::MODE_SPEED, 1'b0, 1'b0, 1'b0);
        wait_drained();

        // receiver held off while the sender keeps offering
        hold_req = 1'b1;
        queue_random(150);
        wait_drained();

        queue_random(300);
        wait_drained();

        send_idle_pct = 71;
        queue_random(300);
        wait_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 71;
        queue_random(300);
        wait_drained();

        send_idle_pct  = 15;
        recv_stall_pct = 15;
        queue_random(275);
        wait_drained();

        // catch any stray results
        repeat (4 * dqd_pkg::PIPE_STAGES) @(negedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
